### sv/ddo_pkg.sv
// Shared types, constants and helpers for the differential-drive odometry block.
package ddo_pkg;

    // Configuration register indexes
    localparam logic REG_METERS_PER_TICK = 1'b0;
    localparam logic REG_TURN_PER_METER  = 1'b1;

    localparam logic [31:0] MPT_RESET = 32'd858993;
    localparam logic [31:0] TPM_RESET = 32'd2147483647;

    // CORDIC sizing
    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned ATAN_ENTRIES     = 24;
    localparam int unsigned ROT_W            = 50;
    localparam int unsigned ANG_W            = 34;

    // Shared multiplier operand and product widths
    localparam int unsigned MUL_W  = 33;
    localparam int unsigned PROD_W = 2 * MUL_W;

    // Reciprocal of the CORDIC gain, scaled by 2^32
    localparam logic [31:0] INV_GAIN = 32'd2608131496;

    localparam logic signed [PROD_W-1:0] S48_MAX = 66'sd140737488355327;
    localparam logic signed [PROD_W-1:0] S48_MIN = -66'sd140737488355328;

    // atan(2^-i) in units of 2^-32 turn, rounded
    localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_DR_CAP,
        S_DIFF,
        S_MAG,
        S_TH_HI,
        S_TH_LO,
        S_G_HI,
        S_G_LO,
        S_G_SUM,
        S_ROT_GO,
        S_ROT,
        S_ACC,
        S_DONE
    } t_state;

    // Clamp a signed value to the signed 48-bit range
    function automatic logic signed [47:0] sat48(input logic signed [PROD_W-1:0] v);
        logic signed [47:0] r;
        if (v > S48_MAX) begin
            r = S48_MAX[47:0];
        end else if (v < S48_MIN) begin
            r = S48_MIN[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

### sv/ddo_mul.sv
// Shared signed multiplier with a registered product.
module ddo_mul (
    input  logic                                  i_clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]      i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]      i_b,
    output logic signed [ddo_pkg::PROD_W-1:0]     o_p
);

    logic signed [ddo_pkg::PROD_W-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### sv/ddo_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle.
module ddo_cordic #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ddo_pkg::ROT_W-1:0]   i_x0,
    input  logic signed [ddo_pkg::ANG_W-1:0]   i_z0,
    output logic                               o_done,
    output logic signed [ddo_pkg::ROT_W-1:0]   o_x,
    output logic signed [ddo_pkg::ROT_W-1:0]   o_y
);

    localparam int unsigned IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic                              r_busy;
    logic                              r_done;
    logic [IW-1:0]                     r_i;
    logic signed [ddo_pkg::ROT_W-1:0]  r_x;
    logic signed [ddo_pkg::ROT_W-1:0]  r_y;
    logic signed [ddo_pkg::ANG_W-1:0]  r_z;

    logic signed [ddo_pkg::ROT_W-1:0]  xs;
    logic signed [ddo_pkg::ROT_W-1:0]  ys;
    logic signed [ddo_pkg::ANG_W-1:0]  ang;

    // Shifted terms and angle step for the current iteration
    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        ang = $signed({2'b00, ddo_pkg::ATAN_TAB[5'(r_i)]});
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x0;
            r_y <= '0;
            r_z <= i_z0;
        end else if (r_busy) begin
            if (!r_z[ddo_pkg::ANG_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

### sv/differential_drive_odometry.sv
// Differential-drive odometry top level: sequencer, pose state and result register.
//
// Input channel (i_in_valid / o_in_ready): command, left and right encoder counts.
// Command 0 (init) stores the counts and clears the pose; command 1 (update)
// integrates the wheel travel into x, y and heading with midpoint heading.
// Output channel (o_out_valid / i_out_ready): one pose per input transaction.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
// meters_per_tick, index 1 sets turn_per_meter; write only while idle.
// Init goes through S_DONE straight to the result register; an update passes through
// one shared 33x33 multiplier, which serves its six products in turn, and the CORDIC
// rotator, which takes one micro-rotation per cycle.
// One transaction is in work at a time: o_in_ready is high only when idle.
// The result register holds a pose until taken, so the next transaction is
// accepted while it waits; a finished pose stalls only if the previous one
// has not yet been taken. Reset clears the pose, the stored counts and the
// result register, and restores the configuration defaults.
module differential_drive_odometry #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic signed [15:0] o_heading,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int unsigned MW = ddo_pkg::MUL_W;
    localparam int unsigned RW = ddo_pkg::ROT_W;

    ddo_pkg::t_state r_state, n_state;

    logic [31:0]         r_mpt, r_tpm;
    logic [31:0]         r_last_l, r_last_r;
    logic [31:0]         r_tl, r_tr;
    logic signed [47:0]  r_dl, r_dr, r_ds;
    logic signed [48:0]  r_diff;
    logic [47:0]         r_mag;
    logic [31:0]         r_thhi, r_dth, r_mid, r_head;
    logic [63:0]         r_ghi;
    logic [47:0]         r_gr;
    logic signed [47:0]  r_posx, r_posy;
    logic                r_out_valid;
    logic signed [31:0]  r_out_x, r_out_y;
    logic signed [15:0]  r_out_head;

    logic signed [MW-1:0]             mul_a, mul_b;
    logic signed [ddo_pkg::PROD_W-1:0] prod;
    logic                             rot_start, rot_done;
    logic signed [RW-1:0]             rot_x0, rot_x, rot_y;
    logic signed [ddo_pkg::ANG_W-1:0] rot_z0;
    logic                             in_acc, out_free, fold, flip;
    logic [31:0]                      ang;
    logic signed [RW-1:0]             gr_ext;
    logic [64:0]                      gsum;
    logic signed [50:0]               sum_x, sum_y;

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_x0    (rot_x0),
        .i_z0    (rot_z0),
        .o_done  (rot_done),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Fold the midpoint angle into the right half plane and set the start vector
    always_comb begin
        fold   = r_mid[31] ^ r_mid[30];
        ang    = {r_mid[31] ^ fold, r_mid[30:0]};
        flip   = r_ds[47] ^ fold;
        gr_ext = $signed({2'b00, r_gr});
        rot_x0 = flip ? -gr_ext : gr_ext;
        rot_z0 = $signed({{2{ang[31]}}, ang});
        gsum   = {1'b0, r_ghi} + {17'd0, prod[63:16]};
        sum_x  = $signed({{3{r_posx[47]}}, r_posx}) + $signed({rot_x[RW-1], rot_x});
        sum_y  = $signed({{3{r_posy[47]}}, r_posy}) + $signed({rot_y[RW-1], rot_y});
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ddo_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = i_command ? ddo_pkg::S_MUL_L : ddo_pkg::S_DONE;
                end
            end
            ddo_pkg::S_MUL_L:  n_state = ddo_pkg::S_MUL_R;
            ddo_pkg::S_MUL_R:  n_state = ddo_pkg::S_DR_CAP;
            ddo_pkg::S_DR_CAP: n_state = ddo_pkg::S_DIFF;
            ddo_pkg::S_DIFF:   n_state = ddo_pkg::S_MAG;
            ddo_pkg::S_MAG:    n_state = ddo_pkg::S_TH_HI;
            ddo_pkg::S_TH_HI:  n_state = ddo_pkg::S_TH_LO;
            ddo_pkg::S_TH_LO:  n_state = ddo_pkg::S_G_HI;
            ddo_pkg::S_G_HI:   n_state = ddo_pkg::S_G_LO;
            ddo_pkg::S_G_LO:   n_state = ddo_pkg::S_G_SUM;
            ddo_pkg::S_G_SUM:  n_state = ddo_pkg::S_ROT_GO;
            ddo_pkg::S_ROT_GO: n_state = ddo_pkg::S_ROT;
            ddo_pkg::S_ROT: begin
                if (rot_done) begin
                    n_state = ddo_pkg::S_ACC;
                end
            end
            ddo_pkg::S_ACC:    n_state = ddo_pkg::S_DONE;
            ddo_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = ddo_pkg::S_IDLE;
                end
            end
            default:           n_state = ddo_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand select
    always_comb begin
        o_in_ready = 1'b0;
        rot_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            ddo_pkg::S_IDLE:   o_in_ready = 1'b1;
            ddo_pkg::S_MUL_L: begin
                mul_a = $signed({r_tl[31], r_tl});
                mul_b = $signed({1'b0, r_mpt});
            end
            ddo_pkg::S_MUL_R: begin
                mul_a = $signed({r_tr[31], r_tr});
                mul_b = $signed({1'b0, r_mpt});
            end
            ddo_pkg::S_TH_HI: begin
                mul_a = $signed({{16{r_diff[48]}}, r_diff[48:32]});
                mul_b = $signed({1'b0, r_tpm});
            end
            ddo_pkg::S_TH_LO: begin
                mul_a = $signed({1'b0, r_diff[31:0]});
                mul_b = $signed({1'b0, r_tpm});
            end
            ddo_pkg::S_G_HI: begin
                mul_a = $signed({1'b0, r_mag[47:16]});
                mul_b = $signed({1'b0, ddo_pkg::INV_GAIN});
            end
            ddo_pkg::S_G_LO: begin
                mul_a = $signed({17'd0, r_mag[15:0]});
                mul_b = $signed({1'b0, ddo_pkg::INV_GAIN});
            end
            ddo_pkg::S_ROT_GO: rot_start = 1'b1;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt <= ddo_pkg::MPT_RESET;
            r_tpm <= ddo_pkg::TPM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ddo_pkg::REG_METERS_PER_TICK: r_mpt <= i_cfg_data;
                ddo_pkg::REG_TURN_PER_METER:  r_tpm <= i_cfg_data;
                default:                      r_mpt <= r_mpt;
            endcase
        end
    end

    // Pose state and stored counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_l <= '0;
            r_last_r <= '0;
            r_posx   <= '0;
            r_posy   <= '0;
            r_head   <= '0;
        end else begin
            if (in_acc) begin
                r_last_l <= i_left_count;
                r_last_r <= i_right_count;
                if (!i_command) begin
                    r_posx <= '0;
                    r_posy <= '0;
                    r_head <= '0;
                end
            end
            if (r_state == ddo_pkg::S_ACC) begin
                r_posx <= ddo_pkg::sat48($signed({{15{sum_x[50]}}, sum_x}));
                r_posy <= ddo_pkg::sat48($signed({{15{sum_y[50]}}, sum_y}));
                r_head <= r_head + r_dth;
            end
        end
    end

    // Update datapath: one step per state
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tl <= i_left_count - r_last_l;
            r_tr <= i_right_count - r_last_r;
        end
        case (r_state)
            ddo_pkg::S_MUL_R:  r_dl <= ddo_pkg::sat48(prod);
            ddo_pkg::S_DR_CAP: r_dr <= ddo_pkg::sat48(prod);
            ddo_pkg::S_DIFF: begin
                r_ds   <= 48'(($signed({r_dl[47], r_dl}) + $signed({r_dr[47], r_dr})) >>> 1);
                r_diff <= $signed({r_dr[47], r_dr}) - $signed({r_dl[47], r_dl});
            end
            ddo_pkg::S_MAG:    r_mag  <= r_ds[47] ? 48'(-r_ds) : r_ds;
            ddo_pkg::S_TH_LO:  r_thhi <= prod[31:0];
            ddo_pkg::S_G_HI:   r_dth  <= r_thhi + prod[63:32];
            ddo_pkg::S_G_LO: begin
                r_ghi <= prod[63:0];
                r_mid <= r_head + {r_dth[31], r_dth[31:1]};
            end
            ddo_pkg::S_G_SUM:  r_gr <= gsum[63:16];
            default:           r_gr <= r_gr;
        endcase
    end

    // Result register: load when the previous pose has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ddo_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddo_pkg::S_DONE && out_free) begin
            r_out_x    <= r_posx[47:16];
            r_out_y    <= r_posy[47:16];
            r_out_head <= r_head[31:16];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pose_x    = r_out_x;
    assign o_pose_y    = r_out_y;
    assign o_heading   = r_out_head;

endmodule

### sv/ddo_checker.sv
// Port-level checks for the odometry block, bound to the top level.
module ddo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_command,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_pose_x,
    input logic signed [31:0] o_pose_y,
    input logic signed [15:0] o_heading
);

    // An accepted transaction leaves the block busy in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while previous transaction still in work");

    // Init with a free result register yields a cleared pose once it passes through S_DONE into the result register
    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_command && !o_out_valid) |=> ##1
        (o_out_valid && o_pose_x == 32'sd0 && o_pose_y == 32'sd0 && o_heading == 16'sd0))
        else $error("init did not produce a cleared pose");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_pose_x) && $stable(o_pose_y) && $stable(o_heading)))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
